// ----- design/cgs_pkg.sv -----
// package with types and constants shared by the cadence gear selector
`timescale 1ns / 1ps

package cgs_pkg;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_DIV,
        ST_STEP,
        ST_DECIDE,
        ST_FINISH
    } state_t;

    // configuration register indexes
    localparam logic [2:0] REG_SET_POINT = 3'd0;
    localparam logic [2:0] REG_RATIO_01  = 3'd1;
    localparam logic [2:0] REG_RATIO_23  = 3'd2;
    localparam logic [2:0] REG_RATIO_45  = 3'd3;
    localparam logic [2:0] REG_RATIO_67  = 3'd4;

    // reset values: set point 80.0 in q8.8, ratios in q4.12 truncated
    localparam logic [15:0] SET_POINT_RST = 16'd20480;
    localparam logic [31:0] RATIO_01_RST  = 32'd660352655;
    localparam logic [31:0] RATIO_23_RST  = 32'd477831700;
    localparam logic [31:0] RATIO_45_RST  = 32'd330176307;
    localparam logic [31:0] RATIO_67_RST  = 32'd252317983;

    localparam logic [2:0] GEAR_RST = 3'd3;

    // saturated cadence, q9.8
    localparam logic [16:0] CAD_MAX = 17'h1FFFF;

    // quotient bits produced by the serial divider
    localparam int unsigned QUO_BITS = 17;

endpackage

// ----- design/cadence_gear_selector_unit.sv -----
// top level of the cadence gear selector: sequencer and shared serial divider
`timescale 1ns / 1ps

// sequence: one cadence evaluation is setup, 17 divider iterations and step, only
//   setup and step when the quotient saturates; an item takes one to GEARS evaluations,
//   a decide step (skipped on an exact match at the current gear) and a hand-off step
// flow: one item at a time, the next accepted only after the hand-off, later while a
//   held result waits on m_tready; all evaluations use the single restoring divider
// reset: synchronous active-low aresetn, gear 3, state, valid and configuration at their defaults
module cadence_gear_selector_unit #(
    parameter int GEARS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] wheel_rpm
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // [2:0] selected_gear, [19:3] cadence_after_shift, rest 0
    // configuration writes
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam logic [2:0] LAST_GEAR = 3'(GEARS - 1);
    localparam logic [4:0] DIV_LAST  = 5'(cgs_pkg::QUO_BITS - 1);

    // control state
    cgs_pkg::state_t state_reg, state_next;
    logic [2:0]  current_gear_reg, current_gear_next;
    logic        m_tvalid_reg, m_tvalid_next;

    // configuration
    logic [15:0] set_point_reg;
    logic [31:0] ratio_reg [4];

    // per-item working registers
    logic [7:0]  rpm_reg, rpm_next;
    logic [2:0]  j_reg, j_next;              // gear being evaluated
    logic        first_reg, first_next;      // evaluating the current gear
    logic        down_reg, down_next;        // walking toward gear 0
    logic        flipped_reg, flipped_next;
    logic [16:0] cur_cad_reg, cur_cad_next;
    logic [16:0] exp_cad_reg, exp_cad_next;
    logic [16:0] prev_cad_reg, prev_cad_next;
    logic [2:0]  res_gear_reg, res_gear_next;
    logic [16:0] res_cad_reg, res_cad_next;
    logic [23:0] m_tdata_reg, m_tdata_next;

    // serial divider
    logic [15:0] div_reg, div_next;
    logic [15:0] rem_reg, rem_next;
    logic [16:0] quo_reg, quo_next;
    logic [4:0]  cnt_reg, cnt_next;

    // combinational helpers
    logic [2:0]  cur_gear;
    logic [31:0] ratio_word;
    logic [15:0] ratio_sel;
    logic [15:0] rpm_x8;
    logic        sat;
    logic [16:0] rem_shift;
    logic        rem_ge;
    logic [16:0] rem_diff;
    logic signed [17:0] err_new;
    logic        err_neg, err_pos;
    logic        at_end;
    logic        flip;
    logic [2:0]  j_stepped;
    logic [16:0] mag_cur, mag_exp, mag_prev;

    // cadence error, cadence minus set point, at scale 2^8
    function automatic logic signed [17:0] err_of(input logic [16:0] cad,
                                                   input logic [15:0] sp);
        err_of = signed'({1'b0, cad}) - signed'({2'b00, sp});
    endfunction

    function automatic logic [16:0] mag_of(input logic signed [17:0] e);
        logic [17:0] neg;
        neg = 18'(-e);
        mag_of = e[17] ? neg[16:0] : e[16:0];
    endfunction

    assign s_tready  = (state_reg == cgs_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // a stored gear beyond the cassette counts as the last gear
    assign cur_gear = (current_gear_reg > LAST_GEAR) ? LAST_GEAR : current_gear_reg;

    // divisor for the gear under evaluation
    assign ratio_word = ratio_reg[j_reg[2:1]];
    assign ratio_sel  = j_reg[0] ? ratio_word[31:16] : ratio_word[15:0];

    // quotient reaches 2^17 exactly when rpm*8 >= ratio
    assign rpm_x8 = {5'b0, rpm_reg, 3'b000};
    assign sat    = (ratio_sel == 16'd0) || (rpm_x8 >= ratio_sel);

    // one restoring iteration; dividend bits below the top are all zero
    assign rem_shift = {rem_reg, 1'b0};
    assign rem_ge    = (rem_shift >= {1'b0, div_reg});
    assign rem_diff  = rem_shift - {1'b0, div_reg};

    // error of the fresh quotient and walk bookkeeping
    assign err_new   = err_of(quo_reg, set_point_reg);
    assign err_neg   = err_new[17];
    assign err_pos   = !err_new[17] && (err_new != 18'sd0);
    assign flip      = down_reg ? err_neg : err_pos;
    assign at_end    = down_reg ? (j_reg == 3'd0) : (j_reg == LAST_GEAR);
    assign j_stepped = down_reg ? (j_reg - 3'd1) : (j_reg + 3'd1);

    assign mag_cur  = mag_of(err_of(cur_cad_reg, set_point_reg));
    assign mag_exp  = mag_of(err_of(exp_cad_reg, set_point_reg));
    assign mag_prev = mag_of(err_of(prev_cad_reg, set_point_reg));

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            cgs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    state_next = cgs_pkg::ST_START;
                end
            end
            cgs_pkg::ST_START: begin
                state_next = sat ? cgs_pkg::ST_STEP : cgs_pkg::ST_DIV;
            end
            cgs_pkg::ST_DIV: begin
                if (cnt_reg == 5'd0) begin
                    state_next = cgs_pkg::ST_STEP;
                end
            end
            cgs_pkg::ST_STEP: begin
                if (first_reg) begin
                    if (err_new == 18'sd0) begin
                        state_next = cgs_pkg::ST_FINISH;
                    end else begin
                        // walk direction follows the sign of the fresh error
                        if (err_neg ? (j_reg == LAST_GEAR) : (j_reg == 3'd0)) begin
                            state_next = cgs_pkg::ST_DECIDE;
                        end else begin
                            state_next = cgs_pkg::ST_START;
                        end
                    end
                end else if (flip || at_end) begin
                    state_next = cgs_pkg::ST_DECIDE;
                end else begin
                    state_next = cgs_pkg::ST_START;
                end
            end
            cgs_pkg::ST_DECIDE: begin
                state_next = cgs_pkg::ST_FINISH;
            end
            cgs_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = cgs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = cgs_pkg::ST_IDLE;
            end
        endcase
    end

    // datapath
    always_comb begin
        current_gear_next = current_gear_reg;
        m_tvalid_next     = m_tvalid_reg;
        rpm_next          = rpm_reg;
        j_next            = j_reg;
        first_next        = first_reg;
        down_next         = down_reg;
        flipped_next      = flipped_reg;
        cur_cad_next      = cur_cad_reg;
        exp_cad_next      = exp_cad_reg;
        prev_cad_next     = prev_cad_reg;
        res_gear_next     = res_gear_reg;
        res_cad_next      = res_cad_reg;
        m_tdata_next      = m_tdata_reg;
        div_next          = div_reg;
        rem_next          = rem_reg;
        quo_next          = quo_reg;
        cnt_next          = cnt_reg;

        // result taken downstream
        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            cgs_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    rpm_next   = s_tdata;
                    j_next     = cur_gear;
                    first_next = 1'b1;
                end
            end
            cgs_pkg::ST_START: begin
                div_next = ratio_sel;
                rem_next = rpm_x8;
                quo_next = sat ? cgs_pkg::CAD_MAX : 17'd0;
                cnt_next = DIV_LAST;
            end
            cgs_pkg::ST_DIV: begin
                rem_next = rem_ge ? rem_diff[15:0] : rem_shift[15:0];
                quo_next = {quo_reg[15:0], rem_ge};
                cnt_next = cnt_reg - 5'd1;
            end
            cgs_pkg::ST_STEP: begin
                first_next = 1'b0;
                if (first_reg) begin
                    cur_cad_next = quo_reg;
                    exp_cad_next = quo_reg;
                    down_next    = err_pos;
                    flipped_next = 1'b0;
                    if (err_new == 18'sd0) begin
                        // exact match keeps the gear
                        res_gear_next = j_reg;
                        res_cad_next  = quo_reg;
                    end else begin
                        j_next = err_pos ? (j_reg - 3'd1) : (j_reg + 3'd1);
                        if (err_pos ? (j_reg == 3'd0) : (j_reg == LAST_GEAR)) begin
                            j_next = j_reg;
                        end
                    end
                end else begin
                    prev_cad_next = exp_cad_reg;
                    exp_cad_next  = quo_reg;
                    flipped_next  = flip;
                    if (!flip && !at_end) begin
                        j_next = j_stepped;
                    end
                end
            end
            cgs_pkg::ST_DECIDE: begin
                res_gear_next = cur_gear;
                res_cad_next  = cur_cad_reg;
                if (mag_exp < mag_cur) begin
                    if (flipped_reg && (mag_prev < mag_exp)) begin
                        // gear just before the sign flip is closer
                        res_gear_next = down_reg ? (j_reg + 3'd1) : (j_reg - 3'd1);
                        res_cad_next  = prev_cad_reg;
                    end else begin
                        // flip gear, or the end gear when no flip was seen
                        res_gear_next = j_reg;
                        res_cad_next  = exp_cad_reg;
                    end
                end
            end
            cgs_pkg::ST_FINISH: begin
                if (!m_tvalid_reg || m_tready) begin
                    current_gear_next = res_gear_reg;
                    m_tvalid_next     = 1'b1;
                    m_tdata_next      = {4'b0000, res_cad_reg, res_gear_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // control registers and configuration
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= cgs_pkg::ST_IDLE;
            current_gear_reg <= cgs_pkg::GEAR_RST;
            m_tvalid_reg     <= 1'b0;
            set_point_reg    <= cgs_pkg::SET_POINT_RST;
            ratio_reg[0]     <= cgs_pkg::RATIO_01_RST;
            ratio_reg[1]     <= cgs_pkg::RATIO_23_RST;
            ratio_reg[2]     <= cgs_pkg::RATIO_45_RST;
            ratio_reg[3]     <= cgs_pkg::RATIO_67_RST;
        end else begin
            state_reg        <= state_next;
            current_gear_reg <= current_gear_next;
            m_tvalid_reg     <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    cgs_pkg::REG_SET_POINT: set_point_reg <= cfg_data[15:0];
                    cgs_pkg::REG_RATIO_01:  ratio_reg[0]  <= cfg_data;
                    cgs_pkg::REG_RATIO_23:  ratio_reg[1]  <= cfg_data;
                    cgs_pkg::REG_RATIO_45:  ratio_reg[2]  <= cfg_data;
                    cgs_pkg::REG_RATIO_67:  ratio_reg[3]  <= cfg_data;
                    default: begin
                        // index beyond the register list: ignored
                    end
                endcase
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        rpm_reg      <= rpm_next;
        j_reg        <= j_next;
        first_reg    <= first_next;
        down_reg     <= down_next;
        flipped_reg  <= flipped_next;
        cur_cad_reg  <= cur_cad_next;
        exp_cad_reg  <= exp_cad_next;
        prev_cad_reg <= prev_cad_next;
        res_gear_reg <= res_gear_next;
        res_cad_reg  <= res_cad_next;
        m_tdata_reg  <= m_tdata_next;
        div_reg      <= div_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        cnt_reg      <= cnt_next;
    end

endmodule

// ----- verif/cadence_gear_selector_unit_tb.sv -----
// self-checking testbench for the cadence gear selector unit
`timescale 1ns / 1ps

module cadence_gear_selector_unit_tb;

    localparam int GEAR_COUNT   = 8;
    localparam int TAIL_CYCLES  = 160;      // wait after the final drain, covers the slowest item
    localparam int IDLE_CYCLES  = 4;        // settle time before a register write
    localparam int LIMIT_CYCLES = 1000000;
    localparam int RANDOM_ITEMS = 936;

    // indexes past the register list, writes there must be dropped
    localparam logic [2:0] REG_SPARE_A = 3'd5;
    localparam logic [2:0] REG_SPARE_B = 3'd6;
    localparam logic [2:0] REG_SPARE_C = 3'd7;

    // shift decision as seen on the result stream
    typedef struct packed {
        logic [2:0]  gear;
        logic [16:0] cad;
    } shift_t;

    // per item: expected value typed in by hand, or left to the predictor
    typedef struct packed {
        logic        known;
        logic [2:0]  gear;
        logic [16:0] cad;
    } hint_t;

    // one row of the directed part: a register write or an rpm sample
    typedef struct packed {
        logic        is_write;
        logic [2:0]  index;
        logic [31:0] data;
        logic [7:0]  rpm;
        logic        known;
        logic [2:0]  gear;
        logic [16:0] cad;
    } drive_row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [31:0] cfg_data  = '0;

    // predictor copy of the block's registers and gear
    logic [15:0] set_point;
    logic [31:0] ratio_words [4];
    logic [2:0]  cur_gear;

    shift_t      pending_shifts [$];
    hint_t       typed_hints [$];
    drive_row_t  directed_rows [$];

    int          fail_count = 0;
    int          cycle_count = 0;
    bit          steady = 1'b0;      // no idling on either side
    int          rpm_walk;
    int          random_sent;
    int          phase;
    int          batch;
    int          mode;

    // monitor scratch
    hint_t       hint;
    shift_t      want;
    shift_t      got;
    logic [2:0]  pred_gear;
    logic [16:0] pred_cad;

    cadence_gear_selector_unit #(
        .GEARS(GEAR_COUNT)
    ) u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // ------------------------------------------------------------------
    // predictor
    // ------------------------------------------------------------------

    function automatic logic [15:0] ratio_of(input int g);
        logic [31:0] w;
        w = ratio_words[(g >> 1) & 3];
        return (g & 1) ? w[31:16] : w[15:0];
    endfunction

    // q9.8 cadence, truncated, saturated, zero ratio saturates
    function automatic logic [16:0] cadence_of(input logic [7:0] rpm, input int g);
        logic [15:0] r;
        logic [27:0] q;
        r = ratio_of(g);
        if (r == 16'd0) begin
            return cgs_pkg::CAD_MAX;
        end
        q = {rpm, 20'd0} / {12'd0, r};
        return (q > {11'd0, cgs_pkg::CAD_MAX}) ? cgs_pkg::CAD_MAX : q[16:0];
    endfunction

    function automatic int gear_error(input logic [7:0] rpm, input int g);
        return int'({15'd0, cadence_of(rpm, g)}) - int'({16'd0, set_point});
    endfunction

    function automatic int magnitude(input int v);
        return (v < 0) ? -v : v;
    endfunction

    // walk toward lower error until the sign flips, then take the better
    // of the flip gear and the one before it; shift only on strict gain
    function automatic void predict_shift(input logic [7:0] rpm, output logic [2:0] gear,
                                          output logic [16:0] cad);
        int cur;
        int pick;
        int cur_err;
        int err_j;
        int err_prev;
        int j;
        int dir;
        bit down;
        bit flipped;
        cur = int'(cur_gear);
        if (cur > GEAR_COUNT - 1) begin
            cur = GEAR_COUNT - 1;
        end
        cur_err = gear_error(rpm, cur);
        pick = cur;
        if (cur_err != 0) begin
            down = cur_err > 0;
            dir = down ? -1 : 1;
            j = cur;
            flipped = 1'b0;
            err_j = 0;
            err_prev = 0;
            while (j >= 0 && j < GEAR_COUNT) begin
                err_prev = err_j;
                err_j = gear_error(rpm, j);
                // a zero error is not a flip, the walk goes on
                if ((err_j > 0 && cur_err < 0) || (err_j < 0 && cur_err > 0)) begin
                    flipped = 1'b1;
                    break;
                end
                j += dir;
            end
            if (magnitude(err_j) < magnitude(cur_err)) begin
                if (!flipped) begin
                    pick = down ? 0 : GEAR_COUNT - 1;
                end else if (magnitude(err_prev) < magnitude(err_j)) begin
                    pick = j - dir;
                end else begin
                    pick = j;
                end
            end
        end
        gear = pick[2:0];
        cad = cadence_of(rpm, pick);
    endfunction

    function automatic void apply_write(input logic [2:0] index, input logic [31:0] data);
        case (index)
            cgs_pkg::REG_SET_POINT: set_point = data[15:0];
            cgs_pkg::REG_RATIO_01:  ratio_words[0] = data;
            cgs_pkg::REG_RATIO_23:  ratio_words[1] = data;
            cgs_pkg::REG_RATIO_45:  ratio_words[2] = data;
            cgs_pkg::REG_RATIO_67:  ratio_words[3] = data;
            default: ;  // spare index, write dropped
        endcase
    endfunction

    // ------------------------------------------------------------------
    // monitor: predicts on each accepted sample, checks each result
    // ------------------------------------------------------------------

    always @(posedge aclk) begin
        if (aresetn) begin
            if (cfg_valid && cfg_ready) begin
                apply_write(cfg_index, cfg_data);
            end
            if (s_tvalid && s_tready) begin
                hint = typed_hints.pop_front();
                predict_shift(s_tdata, pred_gear, pred_cad);
                cur_gear = pred_gear;
                if (hint.known) begin
                    want.gear = hint.gear;
                    want.cad = hint.cad;
                end else begin
                    want.gear = pred_gear;
                    want.cad = pred_cad;
                end
                pending_shifts.push_back(want);
            end
            if (m_tvalid && m_tready) begin
                got.gear = m_tdata[2:0];
                got.cad = m_tdata[19:3];
                if (pending_shifts.size() == 0) begin
                    $display("%0t: result with nothing pending, gear %0d cadence %0d",
                             $time, got.gear, got.cad);
                    fail_count++;
                end else begin
                    want = pending_shifts.pop_front();
                    if (got.gear !== want.gear) begin
                        $display("%0t: selected_gear expected %0d, actual %0d",
                                 $time, want.gear, got.gear);
                        fail_count++;
                    end
                    if (got.cad !== want.cad) begin
                        $display("%0t: cadence_after_shift expected %0d, actual %0d",
                                 $time, want.cad, got.cad);
                        fail_count++;
                    end
                    if (m_tdata[23:20] !== 4'd0) begin
                        $display("%0t: tdata padding expected 0, actual %h",
                                 $time, m_tdata[23:20]);
                        fail_count++;
                    end
                end
            end
        end
    end

    // receiver stalls about 7 percent of the time, none while steady
    always @(posedge aclk) begin
        m_tready <= steady || ($urandom_range(99) >= 7);
    end

    // guard against a hung block
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    // one rpm sample; tvalid is left high so back-to-back samples need no toggle
    task automatic send_item(input logic [7:0] rpm, input logic known,
                             input logic [2:0] gear, input logic [16:0] cad);
        hint_t h;
        h.known = known;
        h.gear = gear;
        h.cad = cad;
        typed_hints.push_back(h);
        if (!steady && $urandom_range(99) < 7) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= rpm;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // one register transaction; caller drops cfg_valid when done
    task automatic write_reg(input logic [2:0] index, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
    endtask

    // stop sending and wait until every pending result is back
    task automatic drain();
        s_tvalid <= 1'b0;
        // the monitor logs the last accepted sample at that same edge
        @(posedge aclk);
        while (pending_shifts.size() != 0) @(posedge aclk);
        repeat (IDLE_CYCLES) @(posedge aclk);
    endtask

    // new settings for a random phase, shaped by mode
    task automatic load_settings(input int sel);
        logic [15:0] r [GEAR_COUNT];
        logic [15:0] sp;
        int v;
        int g;
        case (sel)
            0: begin    // power-on values
                write_reg(cgs_pkg::REG_SET_POINT, {16'd0, cgs_pkg::SET_POINT_RST});
                write_reg(cgs_pkg::REG_RATIO_01, cgs_pkg::RATIO_01_RST);
                write_reg(cgs_pkg::REG_RATIO_23, cgs_pkg::RATIO_23_RST);
                write_reg(cgs_pkg::REG_RATIO_45, cgs_pkg::RATIO_45_RST);
                write_reg(cgs_pkg::REG_RATIO_67, cgs_pkg::RATIO_67_RST);
            end
            default: begin
                v = int'($urandom_range(9000, 16000));
                for (g = 0; g < GEAR_COUNT; g++) begin
                    case (sel)
                        1: r[g] = v[15:0];                          // real cassette, falling
                        2: r[g] = 16'($urandom_range(16'hFFFF));    // anything goes
                        3: begin                                    // extremes
                            case ($urandom_range(3))
                                0: r[g] = 16'd0;
                                1: r[g] = 16'hFFFF;
                                2: r[g] = 16'd1;
                                default: r[g] = 16'($urandom_range(16'hFFFF));
                            endcase
                        end
                        default: r[GEAR_COUNT - 1 - g] = v[15:0];   // rising order
                    endcase
                    v = v - int'($urandom_range(200, 1600));
                    if (v < 1) begin
                        v = 1;
                    end
                end
                case (sel)
                    2: sp = 16'($urandom_range(16'hFFFF));
                    3: sp = ($urandom_range(2) == 0) ? 16'd0 :
                            ($urandom_range(1) == 0) ? 16'hFFFF :
                            16'($urandom_range(16'hFFFF));
                    default: sp = 16'($urandom_range(50, 110) * 256 + $urandom_range(255));
                endcase
                write_reg(cgs_pkg::REG_SET_POINT, {16'($urandom_range(16'hFFFF)), sp});
                write_reg(cgs_pkg::REG_RATIO_01, {r[1], r[0]});
                write_reg(cgs_pkg::REG_RATIO_23, {r[3], r[2]});
                write_reg(cgs_pkg::REG_RATIO_45, {r[5], r[4]});
                write_reg(cgs_pkg::REG_RATIO_67, {r[7], r[6]});
            end
        endcase
        if ($urandom_range(3) == 0) begin
            write_reg(3'($urandom_range(REG_SPARE_A, REG_SPARE_C)), $urandom);
        end
        cfg_valid <= 1'b0;
    endtask

    function automatic drive_row_t item_row(input logic [7:0] rpm, input logic known,
                                            input logic [2:0] gear, input logic [16:0] cad);
        return '{is_write: 1'b0, index: 3'd0, data: 32'd0, rpm: rpm,
                 known: known, gear: gear, cad: cad};
    endfunction

    function automatic drive_row_t write_row(input logic [2:0] index, input logic [31:0] data);
        return '{is_write: 1'b1, index: index, data: data, rpm: 8'd0,
                 known: 1'b0, gear: 3'd0, cad: 17'd0};
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin
        set_point = cgs_pkg::SET_POINT_RST;
        ratio_words[0] = cgs_pkg::RATIO_01_RST;
        ratio_words[1] = cgs_pkg::RATIO_23_RST;
        ratio_words[2] = cgs_pkg::RATIO_45_RST;
        ratio_words[3] = cgs_pkg::RATIO_67_RST;
        cur_gear = cgs_pkg::GEAR_RST;

        // zero rpm after reset: no gear is better, stay in gear 3
        directed_rows.push_back(item_row(8'd0, 1'b1, cgs_pkg::GEAR_RST, 17'd0));
        // all ratios 1.0: cadence is rpm in q9.8, every gear alike
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_01, 32'h1000_1000));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_23, 32'h1000_1000));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_45, 32'h1000_1000));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_67, 32'h1000_1000));
        // exact match with the set point keeps the gear; equal gears also keep it
        directed_rows.push_back(item_row(8'd80, 1'b1, cgs_pkg::GEAR_RST, 17'd20480));
        directed_rows.push_back(item_row(8'd255, 1'b1, cgs_pkg::GEAR_RST, 17'd65280));
        directed_rows.push_back(item_row(8'd0, 1'b1, cgs_pkg::GEAR_RST, 17'd0));
        // zero ratios saturate the cadence
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_01, 32'd0));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_23, 32'd0));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_45, 32'd0));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_67, 32'd0));
        directed_rows.push_back(item_row(8'd128, 1'b1, cgs_pkg::GEAR_RST, cgs_pkg::CAD_MAX));
        // set point extremes; upper data bits are ignored
        directed_rows.push_back(write_row(cgs_pkg::REG_SET_POINT, 32'hFFFF_FFFF));
        directed_rows.push_back(item_row(8'd1, 1'b1, cgs_pkg::GEAR_RST, cgs_pkg::CAD_MAX));
        directed_rows.push_back(write_row(cgs_pkg::REG_SET_POINT, 32'd0));
        directed_rows.push_back(item_row(8'd255, 1'b1, cgs_pkg::GEAR_RST, cgs_pkg::CAD_MAX));
        // zero error mid-walk: gear 3 low, gear 4 exact, gear 5 high
        directed_rows.push_back(write_row(cgs_pkg::REG_SET_POINT,
                                          {16'd0, cgs_pkg::SET_POINT_RST}));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_23, 32'h2000_2000));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_45, 32'h0800_1000));
        // spare indexes must not alias onto real registers
        directed_rows.push_back(write_row(REG_SPARE_A, 32'hFFFF_FFFF));
        directed_rows.push_back(write_row(REG_SPARE_B, 32'h0000_0001));
        directed_rows.push_back(write_row(REG_SPARE_C, 32'h5A5A_A5A5));
        directed_rows.push_back(item_row(8'd80, 1'b0, 3'd0, 17'd0));
        // back to the stock cassette
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_01, cgs_pkg::RATIO_01_RST));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_23, cgs_pkg::RATIO_23_RST));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_45, cgs_pkg::RATIO_45_RST));
        directed_rows.push_back(write_row(cgs_pkg::REG_RATIO_67, cgs_pkg::RATIO_67_RST));
        directed_rows.push_back(item_row(8'd255, 1'b0, 3'd0, 17'd0));
        directed_rows.push_back(item_row(8'd1, 1'b0, 3'd0, 17'd0));
        directed_rows.push_back(item_row(8'h55, 1'b0, 3'd0, 17'd0));
        directed_rows.push_back(item_row(8'hAA, 1'b0, 3'd0, 17'd0));
        directed_rows.push_back(item_row(8'd40, 1'b0, 3'd0, 17'd0));
        directed_rows.push_back(item_row(8'd200, 1'b0, 3'd0, 17'd0));

        // synchronous reset
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed part: writes only once the block has gone idle
        foreach (directed_rows[i]) begin
            if (directed_rows[i].is_write) begin
                if (s_tvalid) begin
                    drain();
                end
                write_reg(directed_rows[i].index, directed_rows[i].data);
            end else begin
                cfg_valid <= 1'b0;
                send_item(directed_rows[i].rpm, directed_rows[i].known,
                          directed_rows[i].gear, directed_rows[i].cad);
            end
        end

        // random part in phases, each with its own register settings
        random_sent = 0;
        phase = 0;
        rpm_walk = 128;
        while (random_sent < RANDOM_ITEMS) begin
            drain();
            steady = (phase == 4 || phase == 5);
            mode = (phase < 5) ? phase : $urandom_range(4);
            load_settings(mode);
            batch = $urandom_range(40, 110);
            for (int k = 0; k < batch && random_sent < RANDOM_ITEMS; k++) begin
                // sender holds off until every result is back
                if (phase == 2 && k == 20) begin
                    drain();
                end
                // mostly a slowly drifting speed, some jumps anywhere
                if ($urandom_range(99) < 15) begin
                    rpm_walk = $urandom_range(255);
                end else begin
                    rpm_walk = rpm_walk + int'($urandom_range(16)) - 8;
                    if (rpm_walk < 0) begin
                        rpm_walk = 0;
                    end else if (rpm_walk > 255) begin
                        rpm_walk = 255;
                    end
                end
                send_item(rpm_walk[7:0], 1'b0, 3'd0, 17'd0);
                random_sent++;
            end
            phase++;
        end

        steady = 1'b0;
        drain();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (fail_count == 0 && pending_shifts.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
